[hw/rtl/cef_pkg.sv]
`timescale 1ns / 1ps

package cef_pkg;

    localparam int MAX_WIDTH      = 2048;
    localparam int MAX_CHANNELS   = 4;
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_WIDTH     = COEF_FRAC_BITS + 4;
    localparam int STORE_DEPTH    = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);
    localparam int COL_W          = $clog2(MAX_WIDTH);
    localparam int CHAN_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    localparam int WIDTH_REG_W    = 12;
    localparam int HEIGHT_W       = 16;
    localparam int CHAN_REG_W     = 3;
    localparam int KROW_W         = 60;
    localparam int KEXT_W         = 3 * COEF_WIDTH;

    localparam int PROD_W         = COEF_WIDTH + 9;
    localparam int ROW_W          = PROD_W + 2;
    localparam int SUM_W          = PROD_W + 4;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = 2;
    localparam int QCOUNT_W       = 3;

    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_CHANNELS     = 3'd2;
    localparam logic [2:0] REG_KERNEL_ROW0  = 3'd3;
    localparam logic [2:0] REG_KERNEL_ROW1  = 3'd4;
    localparam logic [2:0] REG_KERNEL_ROW2  = 3'd5;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    typedef struct packed {
        logic [2:0][2:0][7:0] pix;
        logic                 do_a;
        logic                 do_b;
        logic                 last;
    } job_t;

    typedef struct packed {
        logic [COL_W:0]    width;
        logic [HEIGHT_W-1:0] height;
        logic [CHAN_W:0]   chans;
    } geom_t;

    typedef struct packed {
        logic                empty;
        logic [QCOUNT_W-1:0] count;
    } qstat_t;

    typedef logic [2:0][KROW_W-1:0] kernel_t;

    function automatic logic signed [COEF_WIDTH-1:0] coef_of(
        input logic [KROW_W-1:0] krow,
        input int                col
    );
        logic [KEXT_W-1:0] ext;
        ext = KEXT_W'(krow);
        return ext[col*COEF_WIDTH +: COEF_WIDTH];
    endfunction

endpackage

[hw/rtl/cef_ram.sv]
`timescale 1ns / 1ps

module cef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/cef_front.sv]
`timescale 1ns / 1ps

module cef_front
    import cef_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  geom_t       geom,
    input  logic        restart,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        op,
    input  logic [7:0]  sample_value,
    input  qstat_t      qstat,
    output logic        push,
    output job_t        job
);

    // issue stage counters
    logic [COL_W-1:0]    col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    logic [CHAN_W-1:0]   chan_reg, chan_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [COL_W-1:0]    dcol_reg, dcol_next;
    logic [CHAN_W-1:0]   dchan_reg, dchan_next;
    logic [ADDR_W-1:0]   daddr_reg, daddr_next;

    // second stage
    logic              s1_valid_reg;
    logic              s1_drain_reg;
    logic [7:0]        s1_sample_reg;
    logic [CHAN_W-1:0] s1_chan_reg;
    logic              s1_first_reg;
    logic              s1_row1_reg;
    logic              s1_do_a_reg;
    logic              s1_do_b_reg;
    logic              s1_cap_reg;
    logic              s1_h1_reg;
    logic              s1_last_reg;
    logic [ADDR_W-1:0] s1_addr_reg;

    // last line store write, for read-after-write bypass
    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [7:0]        fwd_above_reg;
    logic [7:0]        fwd_mid_reg;

    logic [2:0][2:0][7:0] win_reg  [MAX_CHANNELS];
    logic [1:0][2:0][7:0] dwin_reg [MAX_CHANNELS];

    logic              accept;
    logic              in_drain;
    logic              take_sample;
    logic              take_drain;
    logic              chan_last;
    logic              col_last;
    logic              dchan_last;
    logic              dcol_last;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;
    logic [7:0]        ram_above;
    logic [7:0]        ram_mid;
    logic [7:0]        above_v;
    logic [7:0]        mid_v;
    logic              bypass;
    logic              wr_en;
    logic [2:0][7:0]   vrow;
    logic [2:0][2:0][7:0] win_old;
    logic [2:0][2:0][7:0] win_new;
    logic [1:0][2:0][7:0] dwin_old;
    logic [1:0][2:0][7:0] dwin_new;
    logic [7:0]        dtop;

    assign item_stall = ({1'b0, qstat.count} + (QCOUNT_W + 1)'(s1_valid_reg))
                        >= (QCOUNT_W + 1)'(QUEUE_DEPTH);
    assign accept      = item_valid && !item_stall;
    assign in_drain    = row_reg >= geom.height;
    assign take_sample = accept && (op == OP_SAMPLE) && !in_drain;
    assign take_drain  = accept && (op == OP_DRAIN) && in_drain;

    assign chan_last  = ({1'b0, chan_reg} + (CHAN_W + 1)'(1)) >= geom.chans;
    assign col_last   = ({1'b0, col_reg} + (COL_W + 1)'(1)) >= geom.width;
    assign dchan_last = ({1'b0, dchan_reg} + (CHAN_W + 1)'(1)) >= geom.chans;
    assign dcol_last  = ({1'b0, dcol_reg} + (COL_W + 1)'(1)) >= geom.width;

    always_comb
    begin
        if (take_drain)
        begin
            rd_addr = dcol_last ? daddr_reg
                                : ADDR_W'({1'b0, daddr_reg} + (ADDR_W + 1)'(geom.chans));
        end
        else
        begin
            rd_addr = addr_reg;
        end
    end

    assign rd_en = take_sample || take_drain;

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        chan_next  = chan_reg;
        addr_next  = addr_reg;
        dcol_next  = dcol_reg;
        dchan_next = dchan_reg;
        daddr_next = daddr_reg;
        if (restart)
        begin
            col_next   = '0;
            row_next   = '0;
            chan_next  = '0;
            addr_next  = '0;
            dcol_next  = '0;
            dchan_next = '0;
            daddr_next = '0;
        end
        else if (take_sample)
        begin
            if (chan_last)
            begin
                chan_next = '0;
                if (col_last)
                begin
                    col_next   = '0;
                    row_next   = row_reg + HEIGHT_W'(1);
                    addr_next  = '0;
                    dcol_next  = '0;
                    dchan_next = '0;
                    daddr_next = '0;
                end
                else
                begin
                    col_next  = col_reg + COL_W'(1);
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end
            else
            begin
                chan_next = chan_reg + CHAN_W'(1);
                addr_next = addr_reg + ADDR_W'(1);
            end
        end
        else if (take_drain)
        begin
            if (dchan_last && dcol_last)
            begin
                col_next   = '0;
                row_next   = '0;
                chan_next  = '0;
                addr_next  = '0;
                dcol_next  = '0;
                dchan_next = '0;
                daddr_next = '0;
            end
            else
            begin
                daddr_next = daddr_reg + ADDR_W'(1);
                if (dchan_last)
                begin
                    dchan_next = '0;
                    dcol_next  = dcol_reg + COL_W'(1);
                end
                else
                begin
                    dchan_next = dchan_reg + CHAN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            chan_reg      <= '0;
            addr_reg      <= '0;
            dcol_reg      <= '0;
            dchan_reg     <= '0;
            daddr_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            chan_reg      <= chan_next;
            addr_reg      <= addr_next;
            dcol_reg      <= dcol_next;
            dchan_reg     <= dchan_next;
            daddr_reg     <= daddr_next;
            s1_valid_reg  <= rd_en;
            if (wr_en)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_drain_reg  <= take_drain;
            s1_sample_reg <= sample_value;
            s1_chan_reg   <= take_drain ? dchan_reg : chan_reg;
            s1_first_reg  <= take_drain ? (dcol_reg == '0) : (col_reg == '0);
            s1_row1_reg   <= row_reg == HEIGHT_W'(1);
            s1_do_a_reg   <= (col_reg != '0) && (row_reg != '0);
            s1_do_b_reg   <= col_last && (row_reg != '0);
            s1_cap_reg    <= (col_reg == '0) && (row_reg == geom.height - HEIGHT_W'(1));
            s1_h1_reg     <= geom.height == HEIGHT_W'(1);
            s1_last_reg   <= dchan_last && dcol_last;
            s1_addr_reg   <= rd_addr;
        end
        if (wr_en)
        begin
            fwd_addr_reg  <= s1_addr_reg;
            fwd_above_reg <= mid_v;
            fwd_mid_reg   <= s1_sample_reg;
        end
    end

    cef_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_line_above (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (mid_v),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_above)
    );

    cef_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_line_middle (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_sample_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_mid)
    );

    assign bypass  = fwd_valid_reg && (fwd_addr_reg == s1_addr_reg);
    assign above_v = bypass ? fwd_above_reg : ram_above;
    assign mid_v   = bypass ? fwd_mid_reg : ram_mid;
    assign wr_en   = s1_valid_reg && !s1_drain_reg;

    assign win_old  = win_reg[s1_chan_reg];
    assign dwin_old = dwin_reg[s1_chan_reg];
    assign dtop     = s1_h1_reg ? mid_v : above_v;

    always_comb
    begin
        vrow[0] = s1_row1_reg ? mid_v : above_v;
        vrow[1] = mid_v;
        vrow[2] = s1_sample_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (s1_first_reg)
            begin
                win_new[i] = {3{vrow[i]}};
            end
            else
            begin
                win_new[i] = {vrow[i], win_old[i][2], win_old[i][1]};
            end
        end
        for (int i = 0; i < 2; i++)
        begin
            if (s1_first_reg)
            begin
                dwin_new[i] = {(i == 0) ? dtop : mid_v, dwin_old[i][1], dwin_old[i][0]};
            end
            else
            begin
                dwin_new[i] = {(i == 0) ? dtop : mid_v, dwin_old[i][2], dwin_old[i][1]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && !s1_drain_reg)
        begin
            win_reg[s1_chan_reg] <= win_new;
            if (s1_cap_reg)
            begin
                dwin_reg[s1_chan_reg] <= {{3{s1_sample_reg}},
                                          {3{s1_h1_reg ? s1_sample_reg : mid_v}}};
            end
        end
        else if (s1_valid_reg && s1_drain_reg)
        begin
            dwin_reg[s1_chan_reg] <= dwin_new;
        end
    end

    always_comb
    begin
        job = '0;
        if (s1_drain_reg)
        begin
            job.pix  = {dwin_new[1], dwin_new[1], dwin_new[0]};
            job.do_a = 1'b1;
            job.do_b = 1'b0;
            job.last = s1_last_reg;
        end
        else
        begin
            job.pix  = win_new;
            job.do_a = s1_do_a_reg;
            job.do_b = s1_do_b_reg;
            job.last = 1'b0;
        end
    end

    assign push = s1_valid_reg && (s1_drain_reg || s1_do_a_reg || s1_do_b_reg);

endmodule

[hw/rtl/cef_queue.sv]
`timescale 1ns / 1ps

module cef_queue
    import cef_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  job_t   job_in,
    input  logic   pop,
    output job_t   job_out,
    output qstat_t qstat
);

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCOUNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCOUNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCOUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= job_in;
        end
    end

    assign job_out     = entry_reg[rd_ptr_reg];
    assign qstat.empty = count_reg == '0;
    assign qstat.count = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg < QCOUNT_W'(QUEUE_DEPTH))
        else $error("transaction queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("transaction queue underflow");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers out of step");

endmodule

[hw/rtl/cef_back.sv]
`timescale 1ns / 1ps

module cef_back
    import cef_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  kernel_t    kernel,
    input  job_t       head,
    input  qstat_t     qstat,
    output logic       pop,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_value,
    output logic       clipped,
    output logic       frame_last
);

    logic                      phase_reg;
    logic                      p_valid_reg, r_valid_reg, t_valid_reg, o_valid_reg;
    logic                      p_last_reg, r_last_reg, t_last_reg;
    logic signed [PROD_W-1:0]  prod_reg [3][3];
    logic signed [ROW_W-1:0]   row_reg  [3];
    logic signed [SUM_W-1:0]   sum_reg;
    logic [7:0]                value_reg;
    logic                      clip_reg;
    logic                      last_reg;

    logic                      advance;
    logic                      issue;
    logic                      two_jobs;
    logic                      sel_b;
    logic [2:0][2:0][7:0]      pix;
    logic [SUM_W-1:0]          mag;
    logic [SUM_W-1:0]          qv;
    logic [7:0]                value_d;
    logic                      clip_d;

    assign advance  = !o_valid_reg || !result_stall;
    assign issue    = advance && !qstat.empty;
    assign two_jobs = head.do_a && head.do_b;
    assign sel_b    = head.do_b && (!head.do_a || phase_reg);
    assign pop      = issue && (!two_jobs || phase_reg);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (sel_b)
            begin
                pix[i] = {head.pix[i][2], head.pix[i][2], head.pix[i][1]};
            end
            else
            begin
                pix[i] = head.pix[i];
            end
        end
    end

    always_comb
    begin
        mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        qv  = mag >> COEF_FRAC_BITS;
        if (sum_reg[SUM_W-1])
        begin
            value_d = 8'd0;
            clip_d  = qv != '0;
        end
        else if (qv > SUM_W'(255))
        begin
            value_d = 8'd255;
            clip_d  = 1'b1;
        end
        else
        begin
            value_d = qv[7:0];
            clip_d  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= 1'b0;
            p_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
            t_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (issue)
            begin
                phase_reg <= two_jobs && !phase_reg;
            end
            p_valid_reg <= issue;
            r_valid_reg <= p_valid_reg;
            t_valid_reg <= r_valid_reg;
            o_valid_reg <= t_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[i][j] <= coef_of(kernel[i], j) * $signed({1'b0, pix[i][j]});
                end
                row_reg[i] <= ROW_W'(prod_reg[i][0]) + ROW_W'(prod_reg[i][1])
                              + ROW_W'(prod_reg[i][2]);
            end
            sum_reg    <= SUM_W'(row_reg[0]) + SUM_W'(row_reg[1]) + SUM_W'(row_reg[2]);
            p_last_reg <= head.last && !sel_b;
            r_last_reg <= p_last_reg;
            t_last_reg <= r_last_reg;
            value_reg  <= value_d;
            clip_reg   <= clip_d;
            last_reg   <= t_last_reg;
        end
    end

    assign result_valid = o_valid_reg;
    assign out_value    = value_reg;
    assign clipped      = clip_reg;
    assign frame_last   = last_reg;

    a_phase_pair: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> !qstat.empty && head.do_a && head.do_b)
        else $error("second job issued without a paired entry");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && result_stall |=> o_valid_reg && $stable(value_reg))
        else $error("result lost under stall");

    a_value_clip: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && clip_reg |-> value_reg == 8'd0 || value_reg == 8'd255)
        else $error("clipped result not at a rail");

endmodule

[hw/rtl/conv3x3_clamped_edge_filter.sv]
`timescale 1ns / 1ps

// 3x3 per-channel filter over a raster stream of interleaved 8-bit samples.
// Item channel: item_valid/item_stall with op and sample_value. op = 0 is a
// sample; op = 1 releases one last-row result once the frame is complete.
// Result channel: result_valid/result_stall with out_value, clipped and
// frame_last. A transaction moves on a rising edge with valid high and stall
// low. Configuration: cfg_valid/cfg_ready (ready is always high), cfg_index
// and cfg_data; write only while idle. Geometry writes restart the frame.
// Throughput: one item per cycle while item_stall is low. An item at the
// right-hand edge that yields two results holds the queue head while the back
// end issues both. From acceptance to result_valid, an item passes the line
// store read at acceptance, one queue slot, then the multiply, row sum and
// total registers, with the saturated result registered last.
// The front end stalls when the four-entry queue plus its own in-flight
// stage would fill. A stalled result register holds, the back end freezes,
// the queue fills and item_stall rises.
// Reset clears counters, queue and pipeline valids; geometry returns to
// 1x1x1 with the identity kernel. Line stores are not cleared.

module conv3x3_clamped_edge_filter
    import cef_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic              op,
    input  logic [7:0]        sample_value,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [7:0]        out_value,
    output logic              clipped,
    output logic              frame_last,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [KROW_W-1:0] cfg_data
);

    logic [WIDTH_REG_W-1:0] width_reg;
    logic [HEIGHT_W-1:0]    height_reg;
    logic [CHAN_REG_W-1:0]  chans_reg;
    kernel_t                kernel_reg;

    logic   cfg_we;
    logic   restart;
    geom_t  geom;
    qstat_t qstat;
    logic   push;
    logic   pop;
    job_t   job_in;
    job_t   job_head;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        restart = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH,
                REG_IMAGE_HEIGHT,
                REG_CHANNELS:    restart = 1'b1;
                default:         restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_REG_W'(1);
            height_reg    <= HEIGHT_W'(1);
            chans_reg     <= CHAN_REG_W'(1);
            kernel_reg[0] <= '0;
            kernel_reg[1] <= KROW_W'(1) << (COEF_FRAC_BITS + COEF_WIDTH);
            kernel_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg     <= cfg_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg    <= cfg_data[HEIGHT_W-1:0];
                REG_CHANNELS:     chans_reg     <= cfg_data[CHAN_REG_W-1:0];
                REG_KERNEL_ROW0:  kernel_reg[0] <= cfg_data;
                REG_KERNEL_ROW1:  kernel_reg[1] <= cfg_data;
                REG_KERNEL_ROW2:  kernel_reg[2] <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
        begin
            geom.width = (COL_W + 1)'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            geom.width = (COL_W + 1)'(MAX_WIDTH);
        end
        else
        begin
            geom.width = (COL_W + 1)'(width_reg);
        end
        geom.height = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
        if (chans_reg == '0)
        begin
            geom.chans = (CHAN_W + 1)'(1);
        end
        else if (32'(chans_reg) > MAX_CHANNELS)
        begin
            geom.chans = (CHAN_W + 1)'(MAX_CHANNELS);
        end
        else
        begin
            geom.chans = (CHAN_W + 1)'(chans_reg);
        end
    end

    cef_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .geom         (geom),
        .restart      (restart),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .op           (op),
        .sample_value (sample_value),
        .qstat        (qstat),
        .push         (push),
        .job          (job_in)
    );

    cef_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (job_in),
        .pop     (pop),
        .job_out (job_head),
        .qstat   (qstat)
    );

    cef_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .kernel       (kernel_reg),
        .head         (job_head),
        .qstat        (qstat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_value    (out_value),
        .clipped      (clipped),
        .frame_last   (frame_last)
    );

endmodule
